// File: hw/rtl/rne_pkg.sv
// Package for the Roman numeral encoder.
// Holds the symbol codes, the queue item type and the greedy step table.
// No dependencies.
package rne_pkg;

    localparam int unsigned VALUE_W = 12;
    localparam int unsigned SYM_W   = 3;
    localparam int unsigned STEP_W  = 10;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    localparam logic [SYM_W-1:0] SYM_I = 3'd0;
    localparam logic [SYM_W-1:0] SYM_V = 3'd1;
    localparam logic [SYM_W-1:0] SYM_X = 3'd2;
    localparam logic [SYM_W-1:0] SYM_L = 3'd3;
    localparam logic [SYM_W-1:0] SYM_C = 3'd4;
    localparam logic [SYM_W-1:0] SYM_D = 3'd5;
    localparam logic [SYM_W-1:0] SYM_M = 3'd6;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               range_error;
    } t_item;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [SYM_W-1:0]  sym1;
        logic [SYM_W-1:0]  sym2;
        logic              pair;
    } t_pick;

    // largest numeral step not above rem
    function automatic t_pick pick_step(input logic [VALUE_W-1:0] rem);
        t_pick p;
        p = '{step: 10'd1, sym1: SYM_I, sym2: SYM_I, pair: 1'b0};
        if (rem >= 12'd1000)     p = '{step: 10'd1000, sym1: SYM_M, sym2: SYM_I, pair: 1'b0};
        else if (rem >= 12'd900) p = '{step: 10'd900,  sym1: SYM_C, sym2: SYM_M, pair: 1'b1};
        else if (rem >= 12'd500) p = '{step: 10'd500,  sym1: SYM_D, sym2: SYM_I, pair: 1'b0};
        else if (rem >= 12'd400) p = '{step: 10'd400,  sym1: SYM_C, sym2: SYM_D, pair: 1'b1};
        else if (rem >= 12'd100) p = '{step: 10'd100,  sym1: SYM_C, sym2: SYM_I, pair: 1'b0};
        else if (rem >= 12'd90)  p = '{step: 10'd90,   sym1: SYM_X, sym2: SYM_C, pair: 1'b1};
        else if (rem >= 12'd50)  p = '{step: 10'd50,   sym1: SYM_L, sym2: SYM_I, pair: 1'b0};
        else if (rem >= 12'd40)  p = '{step: 10'd40,   sym1: SYM_X, sym2: SYM_L, pair: 1'b1};
        else if (rem >= 12'd10)  p = '{step: 10'd10,   sym1: SYM_X, sym2: SYM_I, pair: 1'b0};
        else if (rem >= 12'd9)   p = '{step: 10'd9,    sym1: SYM_I, sym2: SYM_X, pair: 1'b1};
        else if (rem >= 12'd5)   p = '{step: 10'd5,    sym1: SYM_V, sym2: SYM_I, pair: 1'b0};
        else if (rem >= 12'd4)   p = '{step: 10'd4,    sym1: SYM_I, sym2: SYM_V, pair: 1'b1};
        return p;
    endfunction

endpackage

// File: hw/rtl/rne_front.sv
// Front stage of the Roman numeral encoder: takes requests and range-checks them.
// Depends on rne_pkg.
module rne_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rne_pkg::VALUE_W-1:0] i_value,
    output logic                        o_push,
    input  logic                        i_q_ready,
    output rne_pkg::t_item              o_item
);
    import rne_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid && i_q_ready;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.value       <= i_value;
            r_item.range_error <= (i_value == '0) || (i_value > VALUE_MAX);
        end
    end

endmodule

// File: hw/rtl/rne_queue.sv
// Two-entry request queue between front and back of the Roman numeral encoder.
// Depends on rne_pkg.
module rne_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rne_pkg::t_item i_data,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output rne_pkg::t_item o_data
);
    import rne_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    logic [1:0] r_count;
    logic       r_wp;
    logic       r_rp;
    t_item      r_mem [2];
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_count != DEPTH);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            if (w_push && !w_pop)      r_count <= r_count + 2'd1;
            else if (w_pop && !w_push) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: hw/rtl/rne_back.sv
// Back stage of the Roman numeral encoder: emits one symbol per cycle
// while i_ready is high, by greedy subtraction of the numeral steps. Depends on rne_pkg.
module rne_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  rne_pkg::t_item            i_q_data,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [rne_pkg::SYM_W-1:0] o_symbol,
    output logic                      o_last,
    output logic                      o_range_error
);
    import rne_pkg::*;

    logic               r_busy;
    logic               r_err;
    logic               r_half;
    logic [SYM_W-1:0]   r_sym2;
    logic               r_last2;
    logic [VALUE_W-1:0] r_rem;
    logic               r_ovalid;
    logic [SYM_W-1:0]   r_osym;
    logic               r_olast;
    logic               r_oerr;

    logic               w_can_emit;
    logic               w_emit;
    t_pick              w_pick;
    logic [VALUE_W-1:0] w_rem_next;

    assign w_can_emit = !r_ovalid || i_ready;
    assign w_emit     = r_busy && w_can_emit;
    assign o_q_pop    = !r_busy && i_q_valid;
    assign w_pick     = pick_step(r_rem);
    assign w_rem_next = r_rem - {{(VALUE_W-STEP_W){1'b0}}, w_pick.step};

    assign o_valid       = r_ovalid;
    assign o_symbol      = r_osym;
    assign o_last        = r_olast;
    assign o_range_error = r_oerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_half   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_can_emit) r_ovalid <= w_emit;
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_half <= 1'b0;
            end else if (w_emit) begin
                if (r_err) begin
                    r_busy <= 1'b0;
                end else if (r_half) begin
                    r_half <= 1'b0;
                    if (r_last2) r_busy <= 1'b0;
                end else if (w_pick.pair) begin
                    r_half <= 1'b1;
                end else if (w_rem_next == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rem <= i_q_data.value;
            r_err <= i_q_data.range_error;
        end else if (w_emit) begin
            if (r_err) begin
                r_osym  <= SYM_I;
                r_olast <= 1'b1;
                r_oerr  <= 1'b1;
            end else if (r_half) begin
                r_osym  <= r_sym2;
                r_olast <= r_last2;
                r_oerr  <= 1'b0;
            end else begin
                r_rem   <= w_rem_next;
                r_osym  <= w_pick.sym1;
                r_olast <= !w_pick.pair && (w_rem_next == '0);
                r_oerr  <= 1'b0;
                r_sym2  <= w_pick.sym2;
                r_last2 <= (w_rem_next == '0);
            end
        end
    end

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_oerr |-> r_olast)
        else $error("error result without last mark");

    a_half_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> r_busy)
        else $error("pending second symbol while idle");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_busy)
        else $error("request popped but back stage not busy");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && r_half && r_last2 |=> !r_busy)
        else $error("back stage stays busy after last symbol");

endmodule

// File: hw/rtl/roman_numeral_encoder_top.sv
// Top level of the Roman numeral encoder.
// Instantiates rne_front, rne_queue and rne_back; depends on rne_pkg.
//
// Usage:
//   Input channel i_valid/o_ready carries one 12-bit value per request.
//   Output channel o_valid/i_ready carries one symbol per result
//   (0=I 1=V 2=X 3=L 4=C 5=D 6=M), most significant first; o_last marks
//   the final symbol of each numeral.
//   A value of 0 or above 3999 gives one result with o_range_error and
//   o_last set.
//   Path: a request passes the front register, the queue and the back
//   stage's load before its first symbol reaches the output register.
//   Throughput: one symbol per cycle while i_ready is high; the back
//   stage loads the next request only after the last symbol of the
//   previous numeral, and 3888 gives the longest numeral. The back stage's
//   greedy subtract loop sets this rate.
//   The front stage and a two-entry queue keep taking requests while the
//   back stage works; when the receiver holds i_ready low the output
//   register holds its symbol and the back stage waits.
//   Reset (i_rst_n low, synchronous) empties the queue and all stages.
module roman_numeral_encoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rne_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rne_pkg::SYM_W-1:0]   o_symbol,
    output logic                        o_last,
    output logic                        o_range_error
);
    import rne_pkg::*;

    logic  w_push;
    logic  w_q_ready;
    t_item w_front_item;
    logic  w_pop;
    logic  w_q_valid;
    t_item w_q_item;

    rne_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_value   (i_value),
        .o_push    (w_push),
        .i_q_ready (w_q_ready),
        .o_item    (w_front_item)
    );

    rne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_item)
    );

    rne_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_item),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_symbol      (o_symbol),
        .o_last        (o_last),
        .o_range_error (o_range_error)
    );

endmodule

// File: dv/roman_numeral_encoder_top_test.sv
// Self-checking testbench for roman_numeral_encoder_top: directed table, then random requests.
// Symbols are checked against typed table results or a local numeral predictor, with random stalls on both sides.
// Depends on rne_pkg and roman_numeral_encoder_top.
`timescale 1ns / 100ps

module roman_numeral_encoder_top_test;

    import rne_pkg::*;

    localparam int unsigned N_RANDOM   = 196;
    localparam int unsigned HOLD_LEN   = 400;
    localparam int unsigned STALL_MAX  = 2000;
    localparam int unsigned DRAIN_WAIT = 20;
    localparam int unsigned CALM_FIRST = 120;
    localparam int unsigned CALM_LAST  = 170;
    localparam int unsigned HOLD_AT    = 30;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             err;
    } t_sym_rec;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               typed;
        t_sym_rec           res;
    } t_dir_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic [VALUE_W-1:0]   i_value       = '0;
    logic                 i_ready       = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [SYM_W-1:0]     o_symbol;
    logic                 o_last;
    logic                 o_range_error;

    t_sym_rec numeral_q[$];
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    roman_numeral_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_symbol      (o_symbol),
        .o_last        (o_last),
        .o_range_error (o_range_error)
    );

    always #5 i_clk = ~i_clk;

    function automatic void push_sym(input logic [SYM_W-1:0] s);
        numeral_q.push_back('{sym: s, last: 1'b0, err: 1'b0});
    endfunction

    function automatic void push_digit(input int unsigned d, input logic [SYM_W-1:0] one,
                                       input logic [SYM_W-1:0] five,
                                       input logic [SYM_W-1:0] ten);
        if (d == 9) begin
            push_sym(one);
            push_sym(ten);
        end else if (d >= 5) begin
            push_sym(five);
            for (int unsigned k = 5; k < d; k++) push_sym(one);
        end else if (d == 4) begin
            push_sym(one);
            push_sym(five);
        end else begin
            for (int unsigned k = 0; k < d; k++) push_sym(one);
        end
    endfunction

    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        int unsigned rem;
        rem = v;
        if (v == '0 || v > VALUE_MAX) begin
            numeral_q.push_back('{sym: SYM_I, last: 1'b1, err: 1'b1});
            return;
        end
        while (rem >= 1000) begin
            push_sym(SYM_M);
            rem -= 1000;
        end
        push_digit(rem / 100, SYM_C, SYM_D, SYM_M);
        rem = rem % 100;
        push_digit(rem / 10, SYM_X, SYM_L, SYM_C);
        push_digit(rem % 10, SYM_I, SYM_V, SYM_X);
        numeral_q[numeral_q.size()-1].last = 1'b1;
    endfunction

    task automatic send_request(input logic [VALUE_W-1:0] v);
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_gap();
        while (!calm && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) return '0;
        if (pick < 12) return VALUE_W'($urandom_range(4095, 4000));
        return VALUE_W'($urandom_range(3999, 1));
    endfunction

    // rows with a typed result give a single-symbol numeral or a range error
    t_dir_row dir_table[] = '{
        '{12'd0,    1'b1, '{SYM_I, 1'b1, 1'b1}},
        '{12'd1,    1'b1, '{SYM_I, 1'b1, 1'b0}},
        '{12'd5,    1'b1, '{SYM_V, 1'b1, 1'b0}},
        '{12'd10,   1'b1, '{SYM_X, 1'b1, 1'b0}},
        '{12'd50,   1'b1, '{SYM_L, 1'b1, 1'b0}},
        '{12'd100,  1'b1, '{SYM_C, 1'b1, 1'b0}},
        '{12'd500,  1'b1, '{SYM_D, 1'b1, 1'b0}},
        '{12'd1000, 1'b1, '{SYM_M, 1'b1, 1'b0}},
        '{12'd4000, 1'b1, '{SYM_I, 1'b1, 1'b1}},
        '{12'd4095, 1'b1, '{SYM_I, 1'b1, 1'b1}},
        '{12'd2,    1'b0, '0},
        '{12'd4,    1'b0, '0},
        '{12'd8,    1'b0, '0},
        '{12'd9,    1'b0, '0},
        '{12'd40,   1'b0, '0},
        '{12'd90,   1'b0, '0},
        '{12'd400,  1'b0, '0},
        '{12'd900,  1'b0, '0},
        '{12'd1234, 1'b0, '0},
        '{12'd2047, 1'b0, '0},
        '{12'd2222, 1'b0, '0},
        '{12'd3888, 1'b0, '0},
        '{12'd3999, 1'b0, '0},
        '{12'd2730, 1'b0, '0}
    };

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_table[r]) begin
            idle_gap();
            send_request(dir_table[r].value);
            if (dir_table[r].typed) numeral_q.push_back(dir_table[r].res);
            else predict_numeral(dir_table[r].value);
        end
        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            logic [VALUE_W-1:0] v;
            v = random_value();
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            if (n == HOLD_AT) hold_req = 1'b1;
            idle_gap();
            send_request(v);
            predict_numeral(v);
        end
        calm = 1'b0;
        i_valid <= 1'b0;
        while (numeral_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // receiver: random stalls, one long hold-off to back up the pipeline
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else begin
                i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("simulation failed");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (numeral_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected symbol %0d last %0b err %0b",
                                 o_symbol, o_last, o_range_error);
                end else begin
                    t_sym_rec want;
                    want = numeral_q.pop_front();
                    if (o_symbol !== want.sym || o_last !== want.last ||
                        o_range_error !== want.err) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp sym %0d last %0b err %0b, got %0d %0b %0b",
                                     want.sym, want.last, want.err,
                                     o_symbol, o_last, o_range_error);
                    end
                end
            end
        end
    end

endmodule

// File: sim.f
hw/rtl/rne_pkg.sv
hw/rtl/rne_front.sv
hw/rtl/rne_queue.sv
hw/rtl/rne_back.sv
hw/rtl/roman_numeral_encoder_top.sv
dv/roman_numeral_encoder_top_test.sv
